>>> rtl/core/swcd_pkg.sv
// ============================================================================
// swcd_pkg
// Shared codes, stream widths and seven-segment helpers for the stopwatch,
// countdown and wall-clock display block.
// ============================================================================
package swcd_pkg;

	// Stream widths
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;
	localparam int SEG_W       = 7;
	localparam int DIGITS_W    = 6 * SEG_W;

	// Item kinds carried on the input tuser bit
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_KEY  = 1'b1;

	// Key codes
	localparam logic [2:0] KEY_A = 3'd0;
	localparam logic [2:0] KEY_S = 3'd1;
	localparam logic [2:0] KEY_W = 3'd2;
	localparam logic [2:0] KEY_E = 3'd3;
	localparam logic [2:0] KEY_R = 3'd4;
	localparam logic [2:0] KEY_T = 3'd5;

	// Key actions
	localparam logic [1:0] ACT_RELEASE = 2'd0;
	localparam logic [1:0] ACT_PRESS   = 2'd1;

	// Run modes, encoded as {switch S held, switch A held}
	localparam logic [1:0] MODE_OFF       = 2'd0;
	localparam logic [1:0] MODE_STOPWATCH = 2'd1;
	localparam logic [1:0] MODE_CLOCK     = 2'd2;
	localparam logic [1:0] MODE_COUNTDOWN = 2'd3;

	// Active-low segment pattern of one decimal digit; ten and up is blank.
	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] v);
		logic [SEG_W-1:0] s;
		case (v)
			4'd0:    s = 7'h40;
			4'd1:    s = 7'h79;
			4'd2:    s = 7'h24;
			4'd3:    s = 7'h30;
			4'd4:    s = 7'h19;
			4'd5:    s = 7'h12;
			4'd6:    s = 7'h02;
			4'd7:    s = 7'h78;
			4'd8:    s = 7'h00;
			4'd9:    s = 7'h10;
			default: s = 7'h7F;
		endcase
		return s;
	endfunction

	// Tens of a 7-bit value by reciprocal multiply; exact over the whole range.
	function automatic logic [3:0] div10(input logic [6:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return p[14:11];
	endfunction

	// Two digits of a 7-bit value, tens in the upper half.
	function automatic logic [2*SEG_W-1:0] two_digits(input logic [6:0] v);
		logic [3:0] q;
		logic [6:0] r;
		q = div10(v);
		r = v - 7'(q) * 7'd10;
		return {seg_of(q), seg_of(r[3:0])};
	endfunction

	// Three two-digit values as hi:mid:lo, lo in the rightmost digits.
	function automatic logic [DIGITS_W-1:0] show3(input logic [6:0] hi,
		input logic [6:0] mid, input logic [6:0] lo);
		return {two_digits(hi), two_digits(mid), two_digits(lo)};
	endfunction

endpackage

>>> rtl/core/stopwatch_countdown_clock_display.sv
// ============================================================================
// stopwatch_countdown_clock_display
// Stopwatch, wall clock and countdown timer driving six seven-segment digits.
// ============================================================================
// Usage:
// Items arrive on the slave stream, one beat each. s_axis_tuser says what the
// beat is (0 = 10 ms tick, 1 = key event); s_axis_tdata carries the key code,
// key action and the RTC time used by ticks in clock mode. Every input beat
// produces exactly one output beat. m_axis_tdata carries the six active-low
// digit patterns and m_axis_tuser flags whether they are a display update;
// when it is low the digits read as zero and should be ignored.
// Each beat passes one input register, then the state update and digit
// decode land in the output register. The block sustains one beat per
// cycle while m_axis_tready is high, since every state update completes in
// the same cycle it is computed, so the next beat always sees it.
// When the receiver stalls, the result waits in the output register and one
// more beat is still taken into the input register; only then does
// s_axis_tready drop. Reset clears both stages, puts the block in off mode
// with zeroed counters, no switches held, the stopwatch running and the
// countdown paused.
// ============================================================================
module stopwatch_countdown_clock_display (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata fields from bit 0: key_code[2:0], key_action[4:3], rtc_hours[9:5],
	// rtc_minutes[15:10], rtc_seconds[21:16], zero fill [23:22]
	input  logic [swcd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// tuser fields from bit 0: opcode
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata fields from bit 0: digit0[6:0], digit1[13:7], digit2[20:14],
	// digit3[27:21], digit4[34:28], digit5[41:35], zero fill [47:42]
	output logic [swcd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// tuser fields from bit 0: display_write
	output logic                                m_axis_tuser
);
	import swcd_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic       opcode_s1;
	logic [2:0] key_code_s1;
	logic [1:0] key_action_s1;
	logic [4:0] rtc_hours_s1;
	logic [5:0] rtc_minutes_s1;
	logic [5:0] rtc_seconds_s1;

	// Output register stage.
	logic                valid_s2;
	logic [DIGITS_W-1:0] digits_s2;
	logic                write_s2;

	// Architectural state and its next value.
	logic [1:0] run_mode_q,   run_mode_d;
	logic [6:0] hundredths_q, hundredths_d;
	logic [5:0] seconds_q,    seconds_d;
	logic [5:0] minutes_q,    minutes_d;
	logic [4:0] hours_q,      hours_d;
	logic       switch_a_q,   switch_a_d;
	logic       switch_b_q,   switch_b_d;
	logic       sw_halted_q,  sw_halted_d;
	logic       cd_halted_q,  cd_halted_d;

	// Result of the current item.
	logic                write_d;
	logic [6:0]          show_hi, show_mid, show_lo;
	logic [DIGITS_W-1:0] digits_d;

	// Stopwatch increment chain.
	logic [7:0] sw_hund_inc;
	logic       sw_sec_carry;
	logic [6:0] sw_sec_inc;
	logic       sw_min_carry;
	logic [6:0] sw_min_inc;
	logic [6:0] sw_hund_nxt;
	logic [5:0] sw_sec_nxt;
	logic [5:0] sw_min_nxt;

	logic advance;
	logic s_accept;
	logic a_new, b_new;

	// The item in the input register moves on whenever the output register is
	// empty or being emptied this cycle.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	assign sw_hund_inc  = {1'b0, hundredths_q} + 8'd1;
	assign sw_sec_carry = (sw_hund_inc >= 8'd100);
	assign sw_hund_nxt  = sw_sec_carry ? 7'd0 : sw_hund_inc[6:0];
	assign sw_sec_inc   = {1'b0, seconds_q} + {6'd0, sw_sec_carry};
	assign sw_min_carry = (sw_sec_inc >= 7'd60);
	assign sw_sec_nxt   = sw_min_carry ? 6'd0 : sw_sec_inc[5:0];
	assign sw_min_inc   = {1'b0, minutes_q} + {6'd0, sw_min_carry};
	assign sw_min_nxt   = (sw_min_inc >= 7'd60) ? 6'd0 : sw_min_inc[5:0];

	// Switch levels after a press or release of A or S.
	assign a_new = (key_code_s1 == KEY_A) ? (key_action_s1 == ACT_PRESS) : switch_a_q;
	assign b_new = (key_code_s1 == KEY_S) ? (key_action_s1 == ACT_PRESS) : switch_b_q;

	always_comb begin
		run_mode_d   = run_mode_q;
		hundredths_d = hundredths_q;
		seconds_d    = seconds_q;
		minutes_d    = minutes_q;
		hours_d      = hours_q;
		switch_a_d   = switch_a_q;
		switch_b_d   = switch_b_q;
		sw_halted_d  = sw_halted_q;
		cd_halted_d  = cd_halted_q;
		write_d      = 1'b0;
		show_hi      = 7'd0;
		show_mid     = 7'd0;
		show_lo      = 7'd0;

		if (opcode_s1 == OP_TICK) begin
			case (run_mode_q)
				MODE_OFF: begin
					// Off mode keeps everything cleared and shows zeros.
					hundredths_d = 7'd0;
					seconds_d    = 6'd0;
					minutes_d    = 6'd0;
					hours_d      = 5'd0;
					write_d      = 1'b1;
				end
				MODE_STOPWATCH: begin
					if (!sw_halted_q) begin
						hundredths_d = sw_hund_nxt;
						seconds_d    = sw_sec_nxt;
						minutes_d    = sw_min_nxt;
						write_d      = 1'b1;
						show_hi      = {1'b0, sw_min_nxt};
						show_mid     = {1'b0, sw_sec_nxt};
						show_lo      = sw_hund_nxt;
					end
				end
				MODE_CLOCK: begin
					write_d  = 1'b1;
					show_hi  = {2'b00, rtc_hours_s1};
					show_mid = {1'b0, rtc_minutes_s1};
					show_lo  = {1'b0, rtc_seconds_s1};
				end
				default: begin
					// Countdown: borrow through the counters, pause at zero.
					if (!cd_halted_q) begin
						if (hundredths_q != 7'd0) begin
							hundredths_d = hundredths_q - 7'd1;
						end else if (seconds_q != 6'd0) begin
							seconds_d    = seconds_q - 6'd1;
							hundredths_d = 7'd99;
						end else if (minutes_q != 6'd0) begin
							minutes_d    = minutes_q - 6'd1;
							seconds_d    = 6'd59;
							hundredths_d = 7'd99;
						end else if (hours_q != 5'd0) begin
							hours_d      = hours_q - 5'd1;
							minutes_d    = 6'd59;
							seconds_d    = 6'd59;
							hundredths_d = 7'd99;
						end else begin
							cd_halted_d  = 1'b1;
						end
						write_d  = 1'b1;
						show_hi  = {2'b00, hours_d};
						show_mid = {1'b0, minutes_d};
						show_lo  = {1'b0, seconds_d};
					end
				end
			endcase
		end else if (key_code_s1 <= KEY_T) begin
			if ((key_code_s1 == KEY_A || key_code_s1 == KEY_S) &&
			    (key_action_s1 == ACT_PRESS || key_action_s1 == ACT_RELEASE)) begin
				switch_a_d = a_new;
				switch_b_d = b_new;
				run_mode_d = {b_new, a_new};
				// Entering stopwatch mode restarts it from zero.
				if (a_new && !b_new) begin
					hundredths_d = 7'd0;
					seconds_d    = 6'd0;
					minutes_d    = 6'd0;
					sw_halted_d  = 1'b0;
					write_d      = 1'b1;
				end
			end else if (key_action_s1 == ACT_PRESS) begin
				if (run_mode_q == MODE_STOPWATCH) begin
					if (key_code_s1 == KEY_W) begin
						sw_halted_d = !sw_halted_q;
					end else if (key_code_s1 == KEY_E) begin
						hundredths_d = 7'd0;
						seconds_d    = 6'd0;
						minutes_d    = 6'd0;
						sw_halted_d  = 1'b1;
						write_d      = 1'b1;
					end
				end else if (run_mode_q == MODE_COUNTDOWN) begin
					if (cd_halted_q) begin
						// Paused countdown: W starts it, T/R/E set the time.
						if (key_code_s1 == KEY_W) begin
							cd_halted_d = 1'b0;
						end else if (key_code_s1 == KEY_T) begin
							hours_d = (hours_q >= 5'd23) ? 5'd0 : hours_q + 5'd1;
						end else if (key_code_s1 == KEY_R) begin
							minutes_d = (minutes_q >= 6'd59) ? 6'd0 : minutes_q + 6'd1;
						end else begin
							seconds_d = (seconds_q >= 6'd59) ? 6'd0 : seconds_q + 6'd1;
						end
						write_d  = 1'b1;
						show_hi  = {2'b00, hours_d};
						show_mid = {1'b0, minutes_d};
						show_lo  = {1'b0, seconds_d};
					end else if (key_code_s1 == KEY_W) begin
						cd_halted_d = 1'b1;
					end
				end
			end
		end
	end

	assign digits_d = write_d ? show3(show_hi, show_mid, show_lo) : '0;

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			run_mode_q   <= MODE_OFF;
			hundredths_q <= 7'd0;
			seconds_q    <= 6'd0;
			minutes_q    <= 6'd0;
			hours_q      <= 5'd0;
			switch_a_q   <= 1'b0;
			switch_b_q   <= 1'b0;
			sw_halted_q  <= 1'b0;
			cd_halted_q  <= 1'b1;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2     <= 1'b1;
				run_mode_q   <= run_mode_d;
				hundredths_q <= hundredths_d;
				seconds_q    <= seconds_d;
				minutes_q    <= minutes_d;
				hours_q      <= hours_d;
				switch_a_q   <= switch_a_d;
				switch_b_q   <= switch_b_d;
				sw_halted_q  <= sw_halted_d;
				cd_halted_q  <= cd_halted_d;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			opcode_s1      <= s_axis_tuser;
			key_code_s1    <= s_axis_tdata[2:0];
			key_action_s1  <= s_axis_tdata[4:3];
			rtc_hours_s1   <= s_axis_tdata[9:5];
			rtc_minutes_s1 <= s_axis_tdata[15:10];
			rtc_seconds_s1 <= s_axis_tdata[21:16];
		end
		if (advance) begin
			digits_s2 <= digits_d;
			write_s2  <= write_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {(OUT_TDATA_W - DIGITS_W)'(0), digits_s2};
	assign m_axis_tuser  = write_s2;

endmodule

>>> rtl/core/swcd_checker.sv
// ============================================================================
// swcd_checker
// Port-level checks for the stopwatch, countdown and clock display block.
// ============================================================================
module swcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// A beat that does not write the display carries all-zero digits.
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
		else $error("non-write result carries digits");

	// With the output stage empty, the input side is never held off.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// Every accepted beat is followed by a valid result on the output.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
		else $error("accepted beat produced no result");

endmodule

bind stopwatch_countdown_clock_display swcd_checker u_swcd_checker (.*);
